// ===== hdl/assert_macros.svh =====
// Assertion shorthands shared by the packer modules.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define NTBP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define NTBP_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/ntbp_pkg.sv =====
// Shared types and constants of the nucleotide two-bit packer.
// No dependencies; used by the front, queue, back and top-level modules.
`timescale 1ns / 1ps

package ntbp_pkg;

	// default widths of the per-sequence position and the global base offset
	localparam int POSITION_BITS_DEF = 32;
	localparam int OFFSET_BITS_DEF   = 48;

	// global run record index width
	localparam int RUN_OFFSET_BITS = 40;

	// job queue between front and back
	localparam int Q_DEPTH    = 4;
	localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

	// result parts of one job, in delivery order
	localparam int PART_RUN_A = 0;
	localparam int PART_RUN_B = 1;
	localparam int PART_BYTE  = 2;
	localparam int PART_SEQ   = 3;
	localparam int NUM_PARTS  = 4;

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_RUN  = 2'd1,
		KIND_SEQ  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [31:0] pos;
		logic [7:0]  chr;
		logic [31:0] len;
	} run_rec_t;

	// everything one base produces, already cut to the result field widths
	typedef struct packed {
		logic [NUM_PARTS-1:0]       parts;
		run_rec_t                   run_a;
		run_rec_t                   run_b;
		logic [7:0]                 byte_val;
		logic [47:0]                seq_base_pos;
		logic [31:0]                seq_bases;
		logic [RUN_OFFSET_BITS-1:0] first_run_idx;
		logic [31:0]                ambig_count;
	} job_t;

endpackage

// ===== hdl/ntbp_front.sv =====
// Front end of the packer: accepts bases, tracks runs, bytes and offsets,
// and turns each base into at most one job for the queue. Depends on ntbp_pkg.
`timescale 1ns / 1ps

module ntbp_front #(
	parameter int POSITION_BITS = ntbp_pkg::POSITION_BITS_DEF,
	parameter int OFFSET_BITS   = ntbp_pkg::OFFSET_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            base_valid,
	output logic            base_stall,
	input  logic [7:0]      base_char,
	input  logic [3:0]      base_code,
	input  logic            seq_end,
	input  logic            q_full,
	output logic            push,
	output ntbp_pkg::job_t  push_job
);
	import ntbp_pkg::*;

	localparam int PW1 = POSITION_BITS + 1;

	logic [POSITION_BITS-1:0]   base_index_q;
	logic [7:0]                 byte_acc_q;
	logic                       run_open_q;
	logic [3:0]                 run_code_q;
	logic [7:0]                 run_char_q;
	logic [POSITION_BITS-1:0]   run_start_q;
	logic [POSITION_BITS-1:0]   run_count_q;
	logic [31:0]                seq_run_total_q;
	logic [OFFSET_BITS-1:0]     base_offset_q;
	logic [RUN_OFFSET_BITS-1:0] run_offset_q;
	logic [RUN_OFFSET_BITS-1:0] seq_first_run_q;

	logic                       accept;
	logic                       amb;
	logic [1:0]                 phase;
	logic                       close_a;
	logic                       close_b;
	logic                       keep_run;
	logic [3:0]                 code_n;
	logic [7:0]                 char_n;
	logic [POSITION_BITS-1:0]   start_n;
	logic [POSITION_BITS-1:0]   count_n;
	logic [1:0]                 code2;
	logic [2:0]                 shamt;
	logic [7:0]                 acc_n;
	logic                       byte_out;
	logic [1:0]                 n_close;
	logic [RUN_OFFSET_BITS-1:0] run_offset_n;
	logic [31:0]                seq_run_total_n;
	logic [POSITION_BITS-1:0]   size_p;
	logic [POSITION_BITS:0]     size_up;
	logic [POSITION_BITS:0]     size_rnd;

	// stall only on a full queue
	assign base_stall = q_full;
	assign accept     = base_valid && !q_full;

	// classify the base against the open run
	assign amb      = (base_code > 4'd3);
	assign phase    = base_index_q[1:0];
	assign close_a  = run_open_q && (!amb || (base_code != run_code_q));
	assign keep_run = run_open_q && !close_a;
	assign close_b  = seq_end && amb;

	// extend the open run or open a new one
	always_comb begin
		code_n  = run_code_q;
		char_n  = run_char_q;
		start_n = run_start_q;
		count_n = run_count_q;
		if (keep_run) begin
			count_n = run_count_q + POSITION_BITS'(1);
		end else if (amb) begin
			code_n  = base_code;
			char_n  = base_char;
			start_n = base_index_q;
			count_n = POSITION_BITS'(1);
		end
	end

	// place the 2-bit code, first base in the high bits
	assign code2    = amb ? 2'b00 : base_code[1:0];
	assign shamt    = 3'd6 - {phase, 1'b0};
	assign acc_n    = byte_acc_q | (8'(code2) << shamt);
	assign byte_out = (phase == 2'd3) || seq_end;

	// count run records closed by this base
	assign n_close         = {1'b0, close_a} + {1'b0, close_b};
	assign run_offset_n    = run_offset_q + RUN_OFFSET_BITS'(n_close);
	assign seq_run_total_n = seq_run_total_q + 32'(n_close);

	// sequence size and its size rounded up to four bases
	assign size_p   = base_index_q + POSITION_BITS'(1);
	assign size_up  = {1'b0, size_p} + PW1'(3);
	assign size_rnd = {size_up[POSITION_BITS:2], 2'b00};

	// build the job
	always_comb begin
		push_job                  = '0;
		push_job.parts[PART_RUN_A] = close_a;
		push_job.parts[PART_RUN_B] = close_b;
		push_job.parts[PART_BYTE]  = byte_out;
		push_job.parts[PART_SEQ]   = seq_end;
		push_job.run_a.pos        = 32'(run_start_q);
		push_job.run_a.chr        = run_char_q;
		push_job.run_a.len        = 32'(run_count_q);
		push_job.run_b.pos        = 32'(start_n);
		push_job.run_b.chr        = char_n;
		push_job.run_b.len        = 32'(count_n);
		push_job.byte_val         = acc_n;
		push_job.seq_base_pos     = 48'(base_offset_q);
		push_job.seq_bases        = 32'(size_p);
		push_job.first_run_idx    = seq_first_run_q;
		push_job.ambig_count      = seq_run_total_n;
	end

	// drop jobs that produce no result
	assign push = accept && (push_job.parts != '0);

	// advance state on each accepted base
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_index_q    <= '0;
			byte_acc_q      <= '0;
			run_open_q      <= 1'b0;
			run_code_q      <= '0;
			run_char_q      <= '0;
			run_start_q     <= '0;
			run_count_q     <= '0;
			seq_run_total_q <= '0;
			base_offset_q   <= '0;
			run_offset_q    <= '0;
			seq_first_run_q <= '0;
		end else if (accept) begin
			run_open_q   <= amb && !seq_end;
			run_code_q   <= code_n;
			run_char_q   <= char_n;
			run_start_q  <= start_n;
			run_count_q  <= count_n;
			run_offset_q <= run_offset_n;
			byte_acc_q   <= byte_out ? 8'h00 : acc_n;
			if (seq_end) begin
				base_index_q    <= '0;
				seq_run_total_q <= '0;
				seq_first_run_q <= run_offset_n;
				base_offset_q   <= base_offset_q + OFFSET_BITS'(size_rnd);
			end else begin
				base_index_q    <= size_p;
				seq_run_total_q <= seq_run_total_n;
			end
		end
	end

endmodule

// ===== hdl/ntbp_queue.sv =====
// Short job queue between the packer front and back ends.
// Depends on ntbp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ntbp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ntbp_pkg::job_t push_job,
	output logic           full,
	output logic           head_valid,
	output ntbp_pkg::job_t head_job,
	input  logic           pop
);
	import ntbp_pkg::*;

	job_t                  mem_q [Q_DEPTH];
	logic [Q_PTR_BITS-1:0] wr_ptr_q;
	logic [Q_PTR_BITS-1:0] rd_ptr_q;
	logic [Q_PTR_BITS:0]   count_q;

	assign full       = (count_q == (Q_PTR_BITS + 1)'(Q_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];

	// hold job payloads
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (Q_PTR_BITS + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (Q_PTR_BITS + 1)'(1);
			end
		end
	end

	`NTBP_NEVER(a_no_overflow, push && full && !pop, "job pushed into a full queue")
	`NTBP_NEVER(a_no_underflow, pop && !head_valid, "job popped from an empty queue")

endmodule

// ===== hdl/ntbp_back.sv =====
// Back end of the packer: expands each queued job into its result records
// and drives the registered result channel. Depends on ntbp_pkg and macros.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ntbp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  ntbp_pkg::job_t head_job,
	output logic           pop,
	output logic           res_valid,
	input  logic           res_stall,
	output logic [1:0]     kind,
	output logic [7:0]     packed_byte,
	output logic [31:0]    run_position,
	output logic [7:0]     run_char,
	output logic [31:0]    run_length,
	output logic [47:0]    seq_base_pos,
	output logic [31:0]    seq_bases,
	output logic [39:0]    first_run_idx,
	output logic [31:0]    ambig_count,
	output logic           last
);
	import ntbp_pkg::*;

	logic [NUM_PARTS-1:0] sent_q;
	logic [NUM_PARTS-1:0] pending;
	logic [NUM_PARTS-1:0] sel;
	logic                 is_last;
	logic                 load;

	logic                 res_valid_q;
	kind_t                kind_q;
	logic [7:0]           packed_byte_q;
	logic [31:0]          run_position_q;
	logic [7:0]           run_char_q;
	logic [31:0]          run_length_q;
	logic [47:0]          seq_base_pos_q;
	logic [31:0]          seq_bases_q;
	logic [39:0]          first_run_idx_q;
	logic [31:0]          ambig_count_q;
	logic                 last_q;

	kind_t                kind_n;
	logic [7:0]           packed_byte_n;
	logic [31:0]          run_position_n;
	logic [7:0]           run_char_n;
	logic [31:0]          run_length_n;
	logic [47:0]          seq_base_pos_n;
	logic [31:0]          seq_bases_n;
	logic [39:0]          first_run_idx_n;
	logic [31:0]          ambig_count_n;

	// pick the earliest part of the head job not yet sent
	assign pending = head_job.parts & ~sent_q;
	assign sel     = pending & (~pending + NUM_PARTS'(1));
	assign is_last = ((pending & ~sel) == '0);
	assign load    = head_valid && (!res_valid_q || !res_stall);
	assign pop     = load && is_last;

	// format the selected part; fields of other kinds stay zero
	always_comb begin
		kind_n          = KIND_BYTE;
		packed_byte_n   = '0;
		run_position_n  = '0;
		run_char_n      = '0;
		run_length_n    = '0;
		seq_base_pos_n  = '0;
		seq_bases_n     = '0;
		first_run_idx_n = '0;
		ambig_count_n   = '0;
		if (sel[PART_RUN_A]) begin
			kind_n         = KIND_RUN;
			run_position_n = head_job.run_a.pos;
			run_char_n     = head_job.run_a.chr;
			run_length_n   = head_job.run_a.len;
		end else if (sel[PART_RUN_B]) begin
			kind_n         = KIND_RUN;
			run_position_n = head_job.run_b.pos;
			run_char_n     = head_job.run_b.chr;
			run_length_n   = head_job.run_b.len;
		end else if (sel[PART_BYTE]) begin
			kind_n        = KIND_BYTE;
			packed_byte_n = head_job.byte_val;
		end else begin
			kind_n          = KIND_SEQ;
			seq_base_pos_n  = head_job.seq_base_pos;
			seq_bases_n     = head_job.seq_bases;
			first_run_idx_n = head_job.first_run_idx;
			ambig_count_n   = head_job.ambig_count;
		end
	end

	// track sent parts and the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (load) begin
				sent_q      <= is_last ? '0 : (sent_q | sel);
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// hold the result payload until it is taken
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q          <= kind_n;
			packed_byte_q   <= packed_byte_n;
			run_position_q  <= run_position_n;
			run_char_q      <= run_char_n;
			run_length_q    <= run_length_n;
			seq_base_pos_q  <= seq_base_pos_n;
			seq_bases_q     <= seq_bases_n;
			first_run_idx_q <= first_run_idx_n;
			ambig_count_q   <= ambig_count_n;
			last_q          <= is_last;
		end
	end

	assign res_valid     = res_valid_q;
	assign kind          = kind_q;
	assign packed_byte   = packed_byte_q;
	assign run_position  = run_position_q;
	assign run_char      = run_char_q;
	assign run_length    = run_length_q;
	assign seq_base_pos  = seq_base_pos_q;
	assign seq_bases     = seq_bases_q;
	assign first_run_idx = first_run_idx_q;
	assign ambig_count   = ambig_count_q;
	assign last          = last_q;

	`NTBP_NEVER(a_sent_without_job, (sent_q != '0) && !head_valid, "parts marked sent with no job")
	`NTBP_ASSERT(a_sent_subset, !head_valid || ((sent_q & ~head_job.parts) == '0), "sent mask outside job")
	`NTBP_ASSERT(a_job_has_work, !head_valid || (pending != '0), "queued job with nothing left to send")

endmodule

// ===== hdl/nucleotide_two_bit_packer.sv =====
// Top level of the nucleotide two-bit packer: front end, job queue, back end.
// Depends on ntbp_pkg, ntbp_front, ntbp_queue and ntbp_back.
`timescale 1ns / 1ps

// One base is accepted per clock while the four-entry job queue has room; the
// front end finishes all state updates for a base in that cycle. The back end
// sends one result per clock from the queue through a registered output when
// the output is not stalled; a base yields 0 to 4 results (closed run records,
// the packed byte, the sequence record). Bases that yield nothing never enter
// the queue. Sustained input rate is one base per cycle as long as results
// average at most one per base and the output is not stalled; the output port
// sets the limit otherwise. A base's first result passes a queue entry, then
// the output register. The last flag marks the final result of each base.
module nucleotide_two_bit_packer #(
	parameter int POSITION_BITS = ntbp_pkg::POSITION_BITS_DEF,
	parameter int OFFSET_BITS   = ntbp_pkg::OFFSET_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        base_valid,
	output logic        base_stall,
	input  logic [7:0]  base_char,
	input  logic [3:0]  base_code,
	input  logic        seq_end,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [1:0]  kind,
	output logic [7:0]  packed_byte,
	output logic [31:0] run_position,
	output logic [7:0]  run_char,
	output logic [31:0] run_length,
	output logic [47:0] seq_base_pos,
	output logic [31:0] seq_bases,
	output logic [39:0] first_run_idx,
	output logic [31:0] ambig_count,
	output logic        last
);
	import ntbp_pkg::*;

	logic push;
	job_t push_job;
	logic q_full;
	logic head_valid;
	job_t head_job;
	logic pop;

	ntbp_front #(
		.POSITION_BITS(POSITION_BITS),
		.OFFSET_BITS  (OFFSET_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.base_valid(base_valid),
		.base_stall(base_stall),
		.base_char (base_char),
		.base_code (base_code),
		.seq_end   (seq_end),
		.q_full    (q_full),
		.push      (push),
		.push_job  (push_job)
	);

	ntbp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (q_full),
		.head_valid(head_valid),
		.head_job  (head_job),
		.pop       (pop)
	);

	ntbp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_job     (head_job),
		.pop          (pop),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.kind         (kind),
		.packed_byte  (packed_byte),
		.run_position (run_position),
		.run_char     (run_char),
		.run_length   (run_length),
		.seq_base_pos (seq_base_pos),
		.seq_bases    (seq_bases),
		.first_run_idx(first_run_idx),
		.ambig_count  (ambig_count),
		.last         (last)
	);

endmodule
